FILE: src/modbus_rtu_single_register_slave_macros.svh
// Assertion macros shared by the checker of the Modbus RTU slave.
`ifndef MODBUS_RTU_SINGLE_REGISTER_SLAVE_MACROS_SVH
`define MODBUS_RTU_SINGLE_REGISTER_SLAVE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define MBS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition in one cycle implies a consequence in the next cycle.
`define MBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/mbs_pkg.sv
// Shared types, constants and the CRC-16 helper of the Modbus RTU slave.
`timescale 1ns / 1ps
`default_nettype none
package mbs_pkg;

  localparam int FRAME_LEN  = 8;
  localparam int POS_W      = 3;
  localparam int CMD_BYTES  = 6;
  localparam int LEN_W      = 3;
  localparam int CQ_DEPTH   = 2;
  localparam int CQ_PTR_W   = 1;
  localparam int CQ_CNT_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] FUNC_READ        = 8'h03;
  localparam logic [7:0] FUNC_WRITE       = 8'h06;
  localparam logic [7:0] EXC_FLAG         = 8'h80;
  localparam logic [7:0] EXC_ILLEGAL_FUNC = 8'h01;
  localparam logic [7:0] EXC_ILLEGAL_ADDR = 8'h02;
  localparam logic [7:0] READ_BYTE_COUNT  = 8'h02;

  localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REG_ADDR   = 2'd1;

  localparam logic [7:0]  SLAVE_ADDR_RESET = 8'd1;
  localparam logic [15:0] REG_ADDR_RESET   = 16'd1;
  localparam logic [15:0] HOLD_RESET       = 16'd128;

  // Payload lengths of the three response kinds, CRC not counted.
  localparam logic [LEN_W-1:0] LEN_EXC   = 3'd3;
  localparam logic [LEN_W-1:0] LEN_READ  = 3'd5;
  localparam logic [LEN_W-1:0] LEN_WRITE = 3'd6;

  // One response to be sent: payload bytes, first byte in entry 0.
  typedef struct packed {
    logic [LEN_W-1:0]          len;
    logic [CMD_BYTES-1:0][7:0] data;
  } resp_cmd_t;

  // Modbus CRC-16 advanced by one byte, reflected polynomial, one bit a step.
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: src/mbs_front.sv
// Request front end: frames received bytes, checks them and queues responses.
`timescale 1ns / 1ps
`default_nettype none
module mbs_front (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_push,
  output logic                              in_full,
  input  wire  [7:0]                        in_rx_byte,
  input  wire                               cfg_we,
  input  wire  [mbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [mbs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic                              cq_push,
  output mbs_pkg::resp_cmd_t                cq_cmd,
  input  wire                               cq_full
);
  import mbs_pkg::*;

  logic [POS_W-1:0] pos_r;
  logic [15:0]      crc_r;
  logic [15:0]      hold_r;
  logic [7:0]       slave_addr_r;
  logic [15:0]      reg_addr_r;
  logic [7:0]       req_r [FRAME_LEN-1];

  logic        accept;
  logic        last_pos;
  logic [7:0]  func;
  logic [15:0] addr;
  logic [15:0] crc_rx;
  logic        frame_ok;
  logic        addr_ok;
  logic        hold_we;

  assign in_full  = cq_full;
  assign accept   = in_push && !cq_full;
  assign last_pos = (pos_r == POS_W'(FRAME_LEN - 1));
  assign func     = req_r[1];
  assign addr     = {req_r[2], req_r[3]};
  // The eighth byte is the CRC high byte and is still on the input port.
  assign crc_rx   = {in_rx_byte, req_r[6]};
  assign frame_ok = (req_r[0] == slave_addr_r) && (crc_rx == crc_r);
  assign addr_ok  = (addr == reg_addr_r);
  assign cq_push  = accept && last_pos && frame_ok;
  assign hold_we  = cq_push && (func == FUNC_WRITE) && addr_ok;

  // Build the response for a frame that passed the station and CRC checks.
  always_comb begin
    cq_cmd      = '0;
    cq_cmd.data[0] = slave_addr_r;
    priority if (func == FUNC_READ && addr_ok) begin
      cq_cmd.len     = LEN_READ;
      cq_cmd.data[1] = FUNC_READ;
      cq_cmd.data[2] = READ_BYTE_COUNT;
      cq_cmd.data[3] = hold_r[15:8];
      cq_cmd.data[4] = hold_r[7:0];
    end else if (func == FUNC_WRITE && addr_ok) begin
      cq_cmd.len     = LEN_WRITE;
      cq_cmd.data[1] = FUNC_WRITE;
      cq_cmd.data[2] = req_r[2];
      cq_cmd.data[3] = req_r[3];
      cq_cmd.data[4] = req_r[4];
      cq_cmd.data[5] = req_r[5];
    end else if (func == FUNC_READ || func == FUNC_WRITE) begin
      cq_cmd.len     = LEN_EXC;
      cq_cmd.data[1] = func | EXC_FLAG;
      cq_cmd.data[2] = EXC_ILLEGAL_ADDR;
    end else begin
      cq_cmd.len     = LEN_EXC;
      cq_cmd.data[1] = func | EXC_FLAG;
      cq_cmd.data[2] = EXC_ILLEGAL_FUNC;
    end
  end

  // Frame position, running CRC, holding register and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      crc_r        <= CRC_INIT;
      hold_r       <= HOLD_RESET;
      slave_addr_r <= SLAVE_ADDR_RESET;
      reg_addr_r   <= REG_ADDR_RESET;
    end else begin
      if (accept) begin
        pos_r <= pos_r + POS_W'(1);
        if (last_pos) begin
          crc_r <= CRC_INIT;
        end else if (pos_r < POS_W'(FRAME_LEN - 2)) begin
          crc_r <= crc_byte(crc_r, in_rx_byte);
        end
      end
      if (hold_we) begin
        hold_r <= {req_r[4], req_r[5]};
      end
      if (cfg_we) begin
        if (cfg_index == CFG_SLAVE_ADDR) begin
          slave_addr_r <= cfg_wdata[7:0];
        end else if (cfg_index == CFG_REG_ADDR) begin
          reg_addr_r <= cfg_wdata;
        end
      end
    end
  end

  // Request bytes before the last one; no reset needed.
  always_ff @(posedge clk) begin
    if (accept && !last_pos) begin
      req_r[pos_r] <= in_rx_byte;
    end
  end

endmodule
`default_nettype wire

FILE: src/mbs_cmd_fifo.sv
// Short queue of pending responses between the front end and the sender.
`timescale 1ns / 1ps
`default_nettype none
module mbs_cmd_fifo (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  output logic                full,
  input  mbs_pkg::resp_cmd_t  din,
  input  wire                 pop,
  output logic                empty,
  output mbs_pkg::resp_cmd_t  dout
);
  import mbs_pkg::*;

  resp_cmd_t            mem_r [CQ_DEPTH];
  logic [CQ_PTR_W-1:0]  wr_ptr_r;
  logic [CQ_PTR_W-1:0]  rd_ptr_r;
  logic [CQ_CNT_W-1:0]  cnt_r;
  logic                 do_push;
  logic                 do_pop;

  assign full    = (cnt_r == CQ_CNT_W'(CQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + CQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + CQ_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CQ_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CQ_CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule
`default_nettype wire

FILE: src/mbs_back.sv
// Response sender: streams queued responses byte by byte and appends the CRC.
`timescale 1ns / 1ps
`default_nettype none
module mbs_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cq_empty,
  input  mbs_pkg::resp_cmd_t  cq_cmd,
  output logic                cq_pop,
  output logic                out_empty,
  input  wire                 out_pop,
  output logic [7:0]          out_tx_byte,
  output logic                out_last_byte
);
  import mbs_pkg::*;

  logic             busy_r;
  resp_cmd_t        cmd_r;
  logic [LEN_W-1:0] idx_r;
  logic [15:0]      crc_r;
  logic             out_vld_r;
  logic [7:0]       tx_r;
  logic             last_r;

  logic             adv;
  logic             in_payload;
  logic             is_last;
  logic [7:0]       byte_nxt;

  assign cq_pop        = !busy_r && !cq_empty;
  assign adv           = busy_r && (!out_vld_r || out_pop);
  assign in_payload    = (idx_r < cmd_r.len);
  assign is_last       = (idx_r == cmd_r.len + LEN_W'(1));
  assign out_empty     = !out_vld_r;
  assign out_tx_byte   = tx_r;
  assign out_last_byte = last_r;

  // Payload byte, then CRC low byte, then CRC high byte.
  always_comb begin
    if (in_payload) begin
      byte_nxt = cmd_r.data[idx_r];
    end else if (idx_r == cmd_r.len) begin
      byte_nxt = crc_r[7:0];
    end else begin
      byte_nxt = crc_r[15:8];
    end
  end

  // Sequencer over one response and the output beat register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      out_vld_r <= 1'b0;
      idx_r     <= '0;
      crc_r     <= CRC_INIT;
    end else begin
      if (cq_pop) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
        crc_r  <= CRC_INIT;
      end else if (adv) begin
        idx_r <= idx_r + LEN_W'(1);
        if (in_payload) begin
          crc_r <= crc_byte(crc_r, byte_nxt);
        end
        if (is_last) begin
          busy_r <= 1'b0;
        end
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cq_pop) begin
      cmd_r <= cq_cmd;
    end
    if (adv) begin
      tx_r   <= byte_nxt;
      last_r <= is_last;
    end
  end

endmodule
`default_nettype wire

FILE: src/modbus_rtu_single_register_slave.sv
// Top level of the Modbus RTU single-register slave.
// Request bytes are taken one per clock whenever in_full is low; in_full is high whenever
// the two-entry response queue holds two responses, whatever the position within the
// current frame. Frames are fixed eight-byte requests counted from reset. A valid read
// answers with seven bytes, a valid write with eight, an exception with five; the response
// sender puts out one byte per clock while out_pop keeps up, and loads each queued response
// into its command register before it starts on that response's bytes. A response passes
// from the queue through that register to the output beat register.
`timescale 1ns / 1ps
`default_nettype none
module modbus_rtu_single_register_slave (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_push,
  output logic                              in_full,
  input  wire  [7:0]                        in_rx_byte,
  output logic                              out_empty,
  input  wire                               out_pop,
  output logic [7:0]                        out_tx_byte,
  output logic                              out_last_byte,
  input  wire                               cfg_we,
  input  wire  [mbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [mbs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import mbs_pkg::*;

  logic      cq_push;
  logic      cq_full;
  logic      cq_pop;
  logic      cq_empty;
  resp_cmd_t cq_din;
  resp_cmd_t cq_dout;

  // Framing, checking and register access.
  mbs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_rx_byte (in_rx_byte),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cq_push    (cq_push),
    .cq_cmd     (cq_din),
    .cq_full    (cq_full)
  );

  // Pending responses.
  mbs_cmd_fifo u_cmd_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cq_push),
    .full  (cq_full),
    .din   (cq_din),
    .pop   (cq_pop),
    .empty (cq_empty),
    .dout  (cq_dout)
  );

  // Byte streaming with CRC.
  mbs_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cq_empty      (cq_empty),
    .cq_cmd        (cq_dout),
    .cq_pop        (cq_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_tx_byte   (out_tx_byte),
    .out_last_byte (out_last_byte)
  );

endmodule
`default_nettype wire

FILE: src/mbs_checker.sv
// Port-level checker of the Modbus RTU slave and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "modbus_rtu_single_register_slave_macros.svh"
module mbs_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_full,
  input wire       out_empty,
  input wire       out_pop,
  input wire [7:0] out_tx_byte,
  input wire       out_last_byte
);
  logic [2:0] beat_cnt_r;
  logic       out_beat;

  assign out_beat = out_pop && !out_empty;

  // Count the beats of the response in flight.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_cnt_r <= '0;
    end else if (out_beat) begin
      beat_cnt_r <= out_last_byte ? 3'd0 : beat_cnt_r + 3'd1;
    end
  end

  // A waiting beat keeps its value until it is taken.
  `MBS_ASSERT_NEXT(a_out_hold, !out_empty && !out_pop, !out_empty && $stable(out_tx_byte) && $stable(out_last_byte), "stalled response beat changed")

  // Responses are five, seven or eight bytes long.
  `MBS_ASSERT_ALWAYS(a_resp_len, !(!out_empty && out_last_byte) || beat_cnt_r == 3'd4 || beat_cnt_r == 3'd6 || beat_cnt_r == 3'd7, "response of illegal length")

  // No response is longer than eight bytes.
  `MBS_ASSERT_ALWAYS(a_resp_max, !(!out_empty && beat_cnt_r == 3'd7) || out_last_byte, "response runs past eight bytes")

  // The input side only backs up while a response beat is waiting.
  `MBS_ASSERT_ALWAYS(a_full_has_work, !in_full || !out_empty, "input full without pending work")

endmodule

bind modbus_rtu_single_register_slave mbs_checker u_mbs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_full       (in_full),
  .out_empty     (out_empty),
  .out_pop       (out_pop),
  .out_tx_byte   (out_tx_byte),
  .out_last_byte (out_last_byte)
);
`default_nettype wire

FILE: bench/modbus_reply_checker.sv
// Checker that predicts the response beats of the Modbus RTU slave and compares them.
`timescale 1ns / 1ps
module modbus_reply_checker
  import mbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic                  in_full,
  input  logic [7:0]            in_rx_byte,
  input  logic                  out_empty,
  input  logic                  out_pop,
  input  logic [7:0]            out_tx_byte,
  input  logic                  out_last_byte,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatch_count,
  output int                    beats_due,
  output int                    beats_checked
);

  localparam int MAX_REPORTS = 10;

  // One response beat as the slave should send it.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } reply_beat_t;

  reply_beat_t               reply_beats_due[$];
  logic [7:0]                station_addr;
  logic [15:0]               holding_addr;
  logic [15:0]               holding_value;
  logic [POS_W-1:0]          frame_pos;
  logic [FRAME_LEN-1:0][7:0] frame_bytes;
  logic [15:0]               frame_crc;

  initial begin
    mismatch_count = 0;
    beats_due      = 0;
    beats_checked  = 0;
  end

  // Modbus CRC-16 advanced by one byte, least significant bit first.
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] acc;
    acc = crc ^ {8'h00, data};
    repeat (8) acc = {1'b0, acc[15:1]} ^ ({16{acc[0]}} & CRC_POLY);
    return acc;
  endfunction

  // Queue a response payload followed by its CRC, low byte first.
  task automatic queue_reply(input logic [FRAME_LEN-1:0][7:0] payload, input int len);
    logic [15:0] crc;
    crc = CRC_INIT;
    for (int i = 0; i < len; i++) begin
      crc = crc16_step(crc, payload[i]);
      reply_beats_due.push_back({payload[i], 1'b0});
    end
    reply_beats_due.push_back({crc[7:0], 1'b0});
    reply_beats_due.push_back({crc[15:8], 1'b1});
  endtask

  // Take one request byte; on the eighth byte, judge the frame and queue the answer.
  task automatic absorb_request_byte(input logic [7:0] rx);
    logic [7:0]                fn;
    logic [15:0]               reg_sel;
    logic [15:0]               crc_got;
    logic [15:0]               crc_want;
    logic [FRAME_LEN-1:0][7:0] reply;
    frame_bytes[frame_pos] = rx;
    if (frame_pos < CMD_BYTES) begin
      frame_crc = crc16_step(frame_crc, rx);
    end
    if (frame_pos != FRAME_LEN - 1) begin
      frame_pos = frame_pos + 1'b1;
    end else begin
      crc_want  = frame_crc;
      frame_pos = '0;
      frame_crc = CRC_INIT;
      crc_got   = {frame_bytes[7], frame_bytes[6]};
      fn        = frame_bytes[1];
      reg_sel   = {frame_bytes[2], frame_bytes[3]};
      reply     = '0;
      reply[0]  = station_addr;
      // Frames for another station or with a broken CRC are dropped silently.
      if (frame_bytes[0] == station_addr && crc_got == crc_want) begin
        if (fn != FUNC_READ && fn != FUNC_WRITE) begin
          reply[1] = fn | EXC_FLAG;
          reply[2] = EXC_ILLEGAL_FUNC;
          queue_reply(reply, LEN_EXC);
        end else if (reg_sel != holding_addr) begin
          reply[1] = fn | EXC_FLAG;
          reply[2] = EXC_ILLEGAL_ADDR;
          queue_reply(reply, LEN_EXC);
        end else if (fn == FUNC_READ) begin
          reply[1] = fn;
          reply[2] = READ_BYTE_COUNT;
          reply[3] = holding_value[15:8];
          reply[4] = holding_value[7:0];
          queue_reply(reply, LEN_READ);
        end else begin
          // A write echoes the request header and the new value.
          holding_value = {frame_bytes[4], frame_bytes[5]};
          reply[5:1]    = frame_bytes[5:1];
          queue_reply(reply, LEN_WRITE);
        end
      end
    end
  endtask

  // Everything is sampled at the rising edge, results checked before new bytes land.
  always @(posedge clk) begin : monitor
    reply_beat_t want;
    if (!rst_n) begin
      reply_beats_due.delete();
      station_addr  = SLAVE_ADDR_RESET;
      holding_addr  = REG_ADDR_RESET;
      holding_value = HOLD_RESET;
      frame_pos     = '0;
      frame_bytes   = '0;
      frame_crc     = CRC_INIT;
    end else begin
      if (out_pop && !out_empty) begin
        if (reply_beats_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: unexpected response beat: tx_byte %02h last_byte %0b",
                     $time, out_tx_byte, out_last_byte);
          end
        end else begin
          want = reply_beats_due.pop_front();
          beats_checked++;
          if (out_tx_byte !== want.tx_byte || out_last_byte !== want.last_byte) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("%0t: beat %0d: tx_byte expected %02h got %02h, last_byte expected %0b got %0b",
                       $time, beats_checked, want.tx_byte, out_tx_byte,
                       want.last_byte, out_last_byte);
            end
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SLAVE_ADDR: station_addr = cfg_wdata[7:0];
          CFG_REG_ADDR:   holding_addr = cfg_wdata;
          default:        ;
        endcase
      end
      if (in_push && !in_full) begin
        absorb_request_byte(in_rx_byte);
      end
    end
    beats_due = reply_beats_due.size();
  end

endmodule

FILE: bench/tb_modbus_rtu_single_register_slave.sv
// Testbench top for the Modbus RTU slave: drives request frames and gives the verdict.
`timescale 1ns / 1ps
module tb_modbus_rtu_single_register_slave;
  import mbs_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 10;
  // Extra wait after the last predicted beat has arrived, as a margin.
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 200;
  // Watchdog limit on the run length, far beyond the slowest run.
  localparam int CYCLE_LIMIT  = 200000;

  // Register indexes past the end of the map; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef logic [FRAME_LEN-1:0][7:0] request_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_push    = 1'b0;
  logic [7:0]            in_rx_byte = '0;
  logic                  out_pop    = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_full;
  logic                  out_empty;
  logic [7:0]            out_tx_byte;
  logic                  out_last_byte;

  int mismatch_count;
  int beats_due;
  int beats_checked;
  int gap_pct     = 0;
  int stall_pct   = 0;
  int hold_reqs   = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int frames_sent = 0;
  int cycle_count = 0;

  logic [7:0]  cur_station = SLAVE_ADDR_RESET;
  logic [15:0] cur_reg     = REG_ADDR_RESET;

  modbus_rtu_single_register_slave u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_rx_byte    (in_rx_byte),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_tx_byte   (out_tx_byte),
    .out_last_byte (out_last_byte),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  modbus_reply_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_rx_byte     (in_rx_byte),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_tx_byte    (out_tx_byte),
    .out_last_byte  (out_last_byte),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .beats_due      (beats_due),
    .beats_checked  (beats_checked)
  );

  // Clock generation.
  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Response side: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_pop   = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_pop = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // CRC of the six command bytes of a request, as the sender appends it.
  function automatic logic [15:0] request_crc(input request_t req);
    logic [15:0] crc;
    crc = CRC_INIT;
    for (int i = 0; i < CMD_BYTES; i++) begin
      crc = crc ^ {8'h00, req[i]};
      for (int k = 0; k < 8; k++) begin
        crc = {1'b0, crc[15:1]} ^ ({16{crc[0]}} & CRC_POLY);
      end
    end
    return crc;
  endfunction

  // A well-formed eight-byte request with a correct CRC.
  function automatic request_t build_request(input logic [7:0] station, input logic [7:0] fn,
                                             input logic [15:0] reg_sel,
                                             input logic [15:0] value);
    request_t    req;
    logic [15:0] crc;
    req[0] = station;
    req[1] = fn;
    req[2] = reg_sel[15:8];
    req[3] = reg_sel[7:0];
    req[4] = value[15:8];
    req[5] = value[7:0];
    crc    = request_crc(req);
    req[6] = crc[7:0];
    req[7] = crc[15:8];
    return req;
  endfunction

  // Only valid reads and writes if well_formed; else also the error cases and plain noise.
  function automatic request_t random_request(input bit well_formed);
    request_t   req;
    int         kind;
    logic [7:0] fn;
    kind = well_formed ? $urandom_range(0, 5) : $urandom_range(0, 10);
    fn   = ($urandom_range(0, 1) == 0) ? FUNC_READ : FUNC_WRITE;
    case (kind)
      0, 1, 2: req = build_request(cur_station, FUNC_READ, cur_reg, 16'($urandom));
      3, 4, 5: req = build_request(cur_station, FUNC_WRITE, cur_reg, 16'($urandom));
      6: req = build_request(cur_station, fn, cur_reg + 16'($urandom_range(1, 65535)),
                             16'($urandom));
      7: req = build_request(cur_station, 8'($urandom), cur_reg, 16'($urandom));
      8: req = build_request(cur_station + 8'($urandom_range(1, 255)), fn, cur_reg,
                             16'($urandom));
      9: begin
        req      = build_request(cur_station, fn, cur_reg, 16'($urandom));
        req[7:6] = req[7:6] ^ 16'($urandom_range(1, 65535));
      end
      default: req = {$urandom, $urandom};
    endcase
    return req;
  endfunction

  // Offer one byte after a random gap and hold it until the slave takes the beat.
  task automatic offer_byte(input logic [7:0] value);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push    = 1'b1;
    in_rx_byte = value;
    @(posedge clk);
    while (in_full) @(posedge clk);
    @(negedge clk);
  endtask

  // Send bytes lo..hi of a request.
  task automatic send_bytes(input request_t req, input int lo, input int hi);
    for (int i = lo; i <= hi; i++) begin
      offer_byte(req[i]);
    end
    if (hi == FRAME_LEN - 1) begin
      frames_sent++;
    end
  endtask

  // Stop sending and wait until every predicted beat has arrived and the slave is quiet.
  task automatic drain_responses();
    in_push = 1'b0;
    while (beats_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write one configuration register; called only while the slave is idle.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_SLAVE_ADDR: cur_station = value[7:0];
      CFG_REG_ADDR:   cur_reg     = value;
      default:        ;
    endcase
  endtask

  // Change the idle rates at a rising edge so the receiver picks them up cleanly.
  task automatic set_idling(input int send_gap, input int recv_stall);
    @(posedge clk);
    gap_pct   = send_gap;
    stall_pct = recv_stall;
    @(negedge clk);
  endtask

  initial begin : stimulus
    request_t   req;
    logic [7:0] next_station;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // Directed frames at reset settings: write all ones, read it back, unknown function.
    send_bytes(build_request(cur_station, FUNC_WRITE, cur_reg, 16'hFFFF), 0, FRAME_LEN - 1);
    send_bytes(build_request(cur_station, FUNC_READ, cur_reg, 16'h0000), 0, FRAME_LEN - 1);
    send_bytes(build_request(cur_station, 8'hFF, cur_reg, 16'h0000), 0, FRAME_LEN - 1);
    drain_responses();

    // Highest addresses; writes to spare indexes must change nothing.
    write_register(CFG_SLAVE_ADDR, 16'h00FF);
    write_register(CFG_REG_ADDR, 16'hFFFF);
    write_register(CFG_SPARE_A, 16'($urandom));
    write_register(CFG_SPARE_B, 16'($urandom));
    set_idling(63, 0);
    repeat (3) send_bytes(random_request(1'b0), 0, FRAME_LEN - 1);
    drain_responses();

    // Lowest addresses with a slow receiver.
    write_register(CFG_SLAVE_ADDR, 16'h0000);
    write_register(CFG_REG_ADDR, 16'h0000);
    set_idling(0, 63);
    repeat (3) send_bytes(random_request(1'b0), 0, FRAME_LEN - 1);
    drain_responses();

    // Random addresses, both sides idling; the station changes in the middle of a frame.
    write_register(CFG_SLAVE_ADDR, 16'($urandom_range(0, 255)));
    write_register(CFG_REG_ADDR, 16'($urandom));
    set_idling(37, 37);
    next_station = cur_station + 8'($urandom_range(1, 255));
    req = build_request(next_station, FUNC_READ, cur_reg, 16'($urandom));
    send_bytes(req, 0, 3);
    drain_responses();
    write_register(CFG_SLAVE_ADDR, {8'h00, next_station});
    send_bytes(req, 4, FRAME_LEN - 1);
    repeat (2) send_bytes(random_request(1'b0), 0, FRAME_LEN - 1);
    drain_responses();

    // Receiver holds off while valid frames keep coming, so the slave backs up.
    set_idling(0, 0);
    @(posedge clk);
    hold_reqs++;
    @(negedge clk);
    repeat (5) send_bytes(random_request(1'b1), 0, FRAME_LEN - 1);
    drain_responses();

    $display("Sent %0d request frames across five register settings and four idle patterns,",
             frames_sent);
    $display("including a long receiver hold-off; %0d response beats were compared.",
             beats_checked);
    if (mismatch_count == 0 && beats_due == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/mbs_pkg.sv
src/mbs_front.sv
src/mbs_cmd_fifo.sv
src/mbs_back.sv
src/modbus_rtu_single_register_slave.sv
src/mbs_checker.sv
bench/modbus_reply_checker.sv
bench/tb_modbus_rtu_single_register_slave.sv
